>>> hw/rtl/swcc_pkg.sv
// ----------------------------------------------------------------------------
// swcc_pkg: shared constants and types of the write-back cache controller
// Geometry defaults, field widths and the request word passed front to back.
// ----------------------------------------------------------------------------
package swcc_pkg;

  localparam int DEF_SETS        = 64;
  localparam int DEF_WAYS        = 4;
  localparam int DEF_BLOCK_BYTES = 32;
  localparam int ADDR_W          = 32;
  localparam int COUNT_W         = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic MODE_LRU = 1'b0;
  localparam logic MODE_LFU = 1'b1;

  // request word held in the queue between front and back
  typedef struct packed {
    logic              is_write;
    logic [ADDR_W-1:0] address;
  } req_t;

endpackage

>>> hw/rtl/swcc_front.sv
// ----------------------------------------------------------------------------
// swcc_front: request intake and queue
// Accepts commands into a two-entry queue and feeds the back end one word.
// ----------------------------------------------------------------------------
module swcc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          func,
  input  logic [31:0]   address,
  output logic          busy,
  output swcc_pkg::req_t req,
  output logic          req_valid,
  input  logic          req_take
);
  import swcc_pkg::*;

  req_t       q [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       push;

  assign busy      = (count == 2'd2);
  assign push      = start && !busy;
  assign req_valid = (count != 2'd0);
  assign req       = q[rd_ptr];

  // store accepted words
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{is_write: func, address: address};
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (req_take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, req_take};
    end
  end

  a_take_valid: assert property (@(posedge clk) disable iff (rst) req_take |-> req_valid)
    else $error("take from empty queue");
  a_no_over: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue overflow");
  a_full_busy: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !req_take) |=> busy)
    else $error("full queue not busy");

endmodule

>>> hw/rtl/swcc_back.sv
// ----------------------------------------------------------------------------
// swcc_back: set lookup and update
// Reads one set, resolves hit, fill or victim, writes the set back.
// ----------------------------------------------------------------------------
module swcc_back #(
  parameter int SETS        = swcc_pkg::DEF_SETS,
  parameter int WAYS        = swcc_pkg::DEF_WAYS,
  parameter int BLOCK_BYTES = swcc_pkg::DEF_BLOCK_BYTES
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           mode,
  input  swcc_pkg::req_t req,
  input  logic           req_valid,
  output logic           req_take,
  output logic           result_valid,
  output logic           hit,
  output logic [1:0]     way_used,
  output logic           writeback,
  output logic [31:0]    writeback_address
);
  import swcc_pkg::*;

  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_W = WAY_W;
  localparam int TAG_W  = ADDR_W;
  localparam int LINE_W = TAG_W + 2 + RANK_W + COUNT_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic               valid;
    logic               dirty;
    logic [RANK_W-1:0]  rank;
    logic [COUNT_W-1:0] cnt;
  } line_t;

  // one memory row holds the whole set
  logic [WAYS*LINE_W-1:0] mem [SETS];
  logic [WAYS*LINE_W-1:0] rd_row;
  logic [WAYS*LINE_W-1:0] wr_row;
  logic [WAYS*LINE_W-1:0] clr_row;
  line_t                  ln [WAYS];
  line_t                  nl [WAYS];

  logic [1:0]       state;
  logic [SET_W-1:0] clr_idx;
  logic             cur_wr;
  logic [TAG_W-1:0] cur_tag;
  logic [SET_W-1:0] cur_set;

  logic [ADDR_W-1:0] blk;
  logic [SET_W-1:0]  in_set;
  logic [TAG_W-1:0]  in_tag;

  assign blk    = req.address / BLOCK_BYTES;
  assign in_set = SET_W'(blk % SETS);
  assign in_tag = TAG_W'(blk / SETS);
  assign req_take = (state == ST_IDLE) && req_valid;

  // reset row: ranks WAYS-1-way, all else zero
  always_comb begin
    clr_row = '0;
    for (int w = 0; w < WAYS; w++) begin
      clr_row[w*LINE_W + COUNT_W +: RANK_W] = RANK_W'(WAYS - 1 - w);
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) ln[w] = line_t'(rd_row[w*LINE_W +: LINE_W]);
  end

  // resolve the access
  logic             f_hit, f_free;
  logic [WAY_W-1:0] hit_w, free_w, vic_w, sel_w;
  logic [RANK_W-1:0] sel_rank;
  always_comb begin
    f_hit = 1'b0; f_free = 1'b0;
    hit_w = '0; free_w = '0; vic_w = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (ln[w].valid && ln[w].tag == cur_tag) begin f_hit = 1'b1; hit_w = WAY_W'(w); end
      if (!ln[w].valid) begin f_free = 1'b1; free_w = WAY_W'(w); end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (mode == MODE_LRU) begin
        if (ln[w].rank > ln[vic_w].rank) vic_w = WAY_W'(w);
      end else begin
        if (ln[w].cnt < ln[vic_w].cnt) vic_w = WAY_W'(w);
      end
    end
    sel_w = f_hit ? hit_w : (f_free ? free_w : vic_w);
    sel_rank = ln[sel_w].rank;
    for (int w = 0; w < WAYS; w++) begin
      nl[w] = ln[w];
      if (mode == MODE_LRU && ln[w].rank < sel_rank) nl[w].rank = ln[w].rank + 1'b1;
    end
    if (mode == MODE_LRU) nl[sel_w].rank = '0;
    else if (ln[sel_w].cnt != COUNT_MAX) nl[sel_w].cnt = ln[sel_w].cnt + 1'b1;
    if (f_hit) begin
      if (cur_wr) nl[sel_w].dirty = 1'b1;
    end else begin
      nl[sel_w].tag   = cur_tag;
      nl[sel_w].valid = 1'b1;
      nl[sel_w].dirty = cur_wr;
    end
    for (int w = 0; w < WAYS; w++) wr_row[w*LINE_W +: LINE_W] = nl[w];
  end

  logic [2*ADDR_W-1:0] wb_full;
  assign wb_full = (64'(ln[vic_w].tag) * 64'(SETS) + 64'(cur_set)) * 64'(BLOCK_BYTES);

  // memory: read every cycle at the incoming set, write on clear or finish
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) mem[clr_idx] <= clr_row;
    else if (state == ST_LOOK) mem[cur_set] <= wr_row;
    rd_row <= mem[in_set];
  end

  // sequence clear, lookup and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_idx      <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          if (clr_idx == SET_W'(SETS - 1)) state <= ST_IDLE;
          clr_idx <= clr_idx + 1'b1;
        end
        ST_IDLE: begin
          if (req_valid) state <= ST_LOOK;
        end
        ST_LOOK: begin
          state        <= ST_IDLE;
          result_valid <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      cur_wr  <= req.is_write;
      cur_tag <= in_tag;
      cur_set <= in_set;
    end
    if (state == ST_LOOK) begin
      hit               <= f_hit;
      way_used          <= 2'(sel_w);
      writeback         <= !f_hit && !f_free && ln[vic_w].dirty;
      writeback_address <= (!f_hit && !f_free && ln[vic_w].dirty) ?
                           wb_full[ADDR_W-1:0] : '0;
    end
  end

  a_res_after_look: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOK) |=> result_valid)
    else $error("lookup without result");
  a_no_take_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !req_take)
    else $error("take during clear");
  a_wb_miss: assert property (@(posedge clk) disable iff (rst)
    (result_valid && writeback) |-> !hit)
    else $error("writeback on hit");

endmodule

>>> hw/rtl/set_assoc_writeback_cache_ctrl.sv
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache_ctrl: tag and control of a write-back cache
// Two-entry command queue in front of a set read-modify-write back end.
// Timing: an accepted start passes through the queue, the back end's idle
// state and its lookup state; done is registered at the end of the lookup.
// The back end takes no new access until the last one's set row has been
// read and written back. Results cannot be stalled by the receiver.
// Reset: clears the queue, then sweeps every set row to clear the set memory.
// ----------------------------------------------------------------------------
module set_assoc_writeback_cache_ctrl #(
  parameter int SETS        = swcc_pkg::DEF_SETS,
  parameter int WAYS        = swcc_pkg::DEF_WAYS,
  parameter int BLOCK_BYTES = swcc_pkg::DEF_BLOCK_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [31:0] address,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  output logic        done,
  output logic        hit,
  output logic [1:0]  way_used,
  output logic        writeback,
  output logic [31:0] writeback_address
);
  import swcc_pkg::*;

  req_t req;
  logic req_valid;
  logic req_take;
  logic mode;

  assign cfg_ready = 1'b1;

  // hold replacement mode
  always_ff @(posedge clk) begin
    if (rst) mode <= MODE_LRU;
    else if (cfg_valid) mode <= cfg_data;
  end

  swcc_front u_front (
    .clk, .rst, .start, .func, .address, .busy,
    .req, .req_valid, .req_take
  );

  swcc_back #(.SETS(SETS), .WAYS(WAYS), .BLOCK_BYTES(BLOCK_BYTES)) u_back (
    .clk, .rst, .mode, .req, .req_valid, .req_take,
    .result_valid(done), .hit, .way_used, .writeback, .writeback_address
  );

endmodule
